// ===== rtl/flash_page_bitmap_allocator_macros.svh =====
// assertion macros shared by the allocator rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef FLASH_PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define FLASH_PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// condition holds at every edge out of reset
`define FPBA_ASSERT_HOLD(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define FPBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FPBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fpba_pkg.sv =====
// types and constants for the flash page bitmap allocator
// no dependencies
package fpba_pkg;

  localparam int NUM_PAGES = 256;
  localparam int PAGE_W    = 9;                       // width of page and count fields
  localparam int CNT_W     = PAGE_W;
  localparam int IDX_W     = $clog2(NUM_PAGES);       // 0-based page index
  localparam int ROWS      = NUM_PAGES / 8;           // map bytes
  localparam int ROW_W     = $clog2(ROWS);
  localparam int CQ_DEPTH  = 2;
  localparam int CQ_PTR_W  = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_MARK    = 2'd2;
  localparam logic [1:0] REQ_CLEAR   = 2'd3;

  typedef enum logic [2:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_MARK,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [PAGE_W-1:0] page_number;
  } in_req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] granted_page;
    logic              alloc_failed;
    logic [CNT_W-1:0]  free_pages;
  } out_res_t;

endpackage

// ===== rtl/flash_page_bitmap_allocator.sv =====
// channel   dir  handshake         payload
// in_       in   in_push/in_full   in_req  (req_type, page_number)
// out_      out  out_pop/out_empty out_res (granted_page, alloc_failed, free_pages)
//
// one request is worked at a time; a queued request waits while the engine runs.
// on the way to the out_ ports, allocate passes the scan state, reading byte rows in
// order up to the first free page; release and mark pass the update state; clear-all,
// ignored pages and allocate on a full map go from idle to the result state.
// the result register frees the engine only once the previous result is popped.
// rst_n is synchronous; after reset every page is free and no clearing pass is needed.
//
// top level of the flash page bitmap allocator; depends on fpba_pkg,
// fpba_front, fpba_cmdq and fpba_exec
module flash_page_bitmap_allocator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  fpba_pkg::in_req_t  in_req,
  output logic               out_empty,
  input  logic               out_pop,
  output fpba_pkg::out_res_t out_res
);
  import fpba_pkg::*;

  logic cq_full;
  logic cq_push;
  logic cq_pop;
  logic cq_empty;
  cmd_t cq_in_cmd;
  cmd_t cq_head;

  fpba_front u_front (
    .in_push (in_push),
    .in_req  (in_req),
    .in_full (in_full),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .cq_cmd  (cq_in_cmd)
  );

  fpba_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cq_push),
    .push_cmd (cq_in_cmd),
    .full     (cq_full),
    .pop      (cq_pop),
    .empty    (cq_empty),
    .head     (cq_head)
  );

  fpba_exec u_exec (
    .clk       (clk),
    .rst_n     (rst_n),
    .cq_empty  (cq_empty),
    .cq_cmd    (cq_head),
    .cq_pop    (cq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

endmodule

// ===== rtl/fpba_front.sv =====
// front end: classifies requests into commands for the queue
// depends on fpba_pkg
module fpba_front (
  input  logic             in_push,
  input  fpba_pkg::in_req_t in_req,
  output logic             in_full,
  input  logic             cq_full,
  output logic             cq_push,
  output fpba_pkg::cmd_t   cq_cmd
);
  import fpba_pkg::*;

  logic             page_ok;
  logic [PAGE_W-1:0] page_m1;

  assign page_ok = (in_req.page_number != '0) &&
                   (in_req.page_number <= PAGE_W'(NUM_PAGES));
  assign page_m1 = in_req.page_number - PAGE_W'(1);

  assign in_full = cq_full;
  assign cq_push = in_push && !cq_full;

  always_comb begin
    cq_cmd.idx = page_m1[IDX_W-1:0];
    case (in_req.req_type)
      REQ_ALLOC:   cq_cmd.op = OP_ALLOC;
      REQ_RELEASE: cq_cmd.op = page_ok ? OP_RELEASE : OP_NOP;
      REQ_MARK:    cq_cmd.op = page_ok ? OP_MARK : OP_NOP;
      REQ_CLEAR:   cq_cmd.op = OP_CLEAR;
      default:     cq_cmd.op = OP_NOP;
    endcase
  end

endmodule

// ===== rtl/fpba_cmdq.sv =====
// short command queue between front end and execution engine
// depends on fpba_pkg
module fpba_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fpba_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output fpba_pkg::cmd_t head
);
  import fpba_pkg::*;

  cmd_t                entry_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_ptr_r;
  logic [CQ_PTR_W-1:0] rd_ptr_r;
  logic [CQ_CNT_W-1:0] cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rd_ptr_r];

  function automatic logic [CQ_PTR_W-1:0] ptr_inc(input logic [CQ_PTR_W-1:0] p);
    ptr_inc = (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + CQ_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CQ_CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/fpba_exec.sv =====
// execution engine: bitmap memory, first-fit scan, free count, result register
// depends on fpba_pkg and the allocator assertion macros
`include "flash_page_bitmap_allocator_macros.svh"
module fpba_exec (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cq_empty,
  input  fpba_pkg::cmd_t    cq_cmd,
  output logic              cq_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output fpba_pkg::out_res_t out_res
);
  import fpba_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t           state_r;
  cmd_t             cmd_r;
  logic [ROW_W-1:0] addr_r;
  logic [CNT_W-1:0] free_r;
  logic             res_valid_r;
  out_res_t         res_r;
  out_res_t         pend_r;

  // map memory, one byte per row; rows not written since clear read as zero
  logic [7:0]       map_mem [ROWS];
  logic [7:0]       mem_q;
  logic             rowv_q;
  logic [ROWS-1:0]  rowv_r;

  logic [ROW_W-1:0] rd_addr;
  logic             we;
  logic [ROW_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic             clr_all;

  logic [7:0]       byte_cur;
  logic [7:0]       bit_mask;
  logic             bit_set;
  logic             has_zero;
  logic [2:0]       first_zero;
  logic [IDX_W-1:0] found_idx;
  logic             slot_free;
  logic             res_load;

  assign byte_cur  = rowv_q ? mem_q : 8'h00;
  assign bit_mask  = 8'h01 << cmd_r.idx[2:0];
  assign bit_set   = |(byte_cur & bit_mask);
  assign found_idx = {addr_r, first_zero};
  assign slot_free = !res_valid_r || out_pop;
  assign res_load  = (state_r == ST_DONE) && slot_free;
  assign cq_pop    = (state_r == ST_IDLE) && !cq_empty;
  assign clr_all   = cq_pop && (cq_cmd.op == OP_CLEAR);
  assign out_empty = !res_valid_r;
  assign out_res   = res_r;

  // lowest clear bit of the current row
  always_comb begin
    has_zero   = 1'b0;
    first_zero = '0;
    for (int b = 7; b >= 0; b--) begin
      if (!byte_cur[b]) begin
        has_zero   = 1'b1;
        first_zero = 3'(b);
      end
    end
  end

  always_comb begin
    rd_addr = addr_r;
    case (state_r)
      ST_IDLE: rd_addr = (cq_cmd.op == OP_ALLOC) ? '0 : cq_cmd.idx[IDX_W-1:3];
      ST_SCAN: rd_addr = addr_r + ROW_W'(1);
      default: rd_addr = addr_r;
    endcase
  end

  always_comb begin
    we      = 1'b0;
    wr_addr = cmd_r.idx[IDX_W-1:3];
    wr_data = byte_cur;
    case (state_r)
      ST_ACC: begin
        if (cmd_r.op == OP_RELEASE) begin
          we      = bit_set;
          wr_data = byte_cur & ~bit_mask;
        end else begin
          we      = !bit_set;
          wr_data = byte_cur | bit_mask;
        end
      end
      ST_SCAN: begin
        we      = has_zero;
        wr_addr = addr_r;
        wr_data = byte_cur | (8'h01 << first_zero);
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      map_mem[wr_addr] <= wr_data;
    end
    mem_q <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rowv_r <= '0;
      rowv_q <= 1'b0;
    end else begin
      rowv_q <= rowv_r[rd_addr];
      if (clr_all) begin
        rowv_r <= '0;
      end else if (we) begin
        rowv_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_r      <= CNT_W'(NUM_PAGES);
      res_valid_r <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_r <= 1'b1;
      end else if (out_pop && res_valid_r) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (cq_pop) begin
            cmd_r  <= cq_cmd;
            addr_r <= '0;
            case (cq_cmd.op)
              OP_ALLOC: begin
                if (free_r == '0) begin
                  pend_r  <= '{granted_page: '0, alloc_failed: 1'b1, free_pages: free_r};
                  state_r <= ST_DONE;
                end else begin
                  pend_r  <= '{granted_page: '0, alloc_failed: 1'b0, free_pages: free_r};
                  state_r <= ST_SCAN;
                end
              end
              OP_RELEASE, OP_MARK: begin
                pend_r  <= '{granted_page: '0, alloc_failed: 1'b0, free_pages: free_r};
                state_r <= ST_ACC;
              end
              OP_CLEAR: begin
                free_r  <= CNT_W'(NUM_PAGES);
                pend_r  <= '{granted_page: '0, alloc_failed: 1'b0,
                             free_pages: CNT_W'(NUM_PAGES)};
                state_r <= ST_DONE;
              end
              default: begin
                pend_r  <= '{granted_page: '0, alloc_failed: 1'b0, free_pages: free_r};
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_ACC: begin
          if (cmd_r.op == OP_RELEASE && bit_set) begin
            free_r            <= free_r + CNT_W'(1);
            pend_r.free_pages <= free_r + CNT_W'(1);
          end else if (cmd_r.op == OP_MARK && !bit_set) begin
            free_r            <= free_r - CNT_W'(1);
            pend_r.free_pages <= free_r - CNT_W'(1);
          end
          state_r <= ST_DONE;
        end
        ST_SCAN: begin
          if (has_zero) begin
            free_r  <= free_r - CNT_W'(1);
            pend_r  <= '{granted_page: PAGE_W'(found_idx) + PAGE_W'(1),
                         alloc_failed: 1'b0,
                         free_pages:   free_r - CNT_W'(1)};
            state_r <= ST_DONE;
          end else begin
            addr_r <= addr_r + ROW_W'(1);
          end
        end
        ST_DONE: begin
          // result transfer waits for the output register to drain
          if (res_load) begin
            res_r   <= pend_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  `FPBA_ASSERT_HOLD(a_free_range, free_r <= CNT_W'(NUM_PAGES), "free count above page total")
  `FPBA_ASSERT_IMP(a_scan_has_free, state_r == ST_SCAN, free_r != '0, "scan with no free page")
  `FPBA_ASSERT_IMP(a_fail_no_grant, res_valid_r && res_r.alloc_failed, res_r.granted_page == '0, "failed allocate carries a page")
  `FPBA_ASSERT_NXT(a_clear_full, clr_all, free_r == CNT_W'(NUM_PAGES), "clear did not restore free count")

endmodule

// ===== tb/sv/flash_page_bitmap_allocator_checker.sv =====
// result checker for the flash page bitmap allocator: watches both queue ports,
// keeps its own page map to predict every result and compares in order
// depends on fpba_pkg
`timescale 1ns / 100ps
module flash_page_bitmap_allocator_checker
  import fpba_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  input  logic     in_full,
  input  in_req_t  in_req,
  input  logic     out_empty,
  input  logic     out_pop,
  input  out_res_t out_res,
  output int       fail_count,
  output int       pending_results
);

  localparam int REPORT_LIMIT = 10;

  bit [NUM_PAGES-1:0] page_taken;
  logic [CNT_W-1:0]   free_left;
  out_res_t           grant_q[$];
  int                 mismatches = 0;
  int                 results_seen = 0;

  // applies one request to the shadow map and returns the result it should give
  function automatic out_res_t apply_request(in_req_t r);
    out_res_t    res;
    int unsigned page;
    bit          page_ok;
    bit          found;
    res     = '0;
    page    = r.page_number;
    page_ok = (page >= 1) && (page <= NUM_PAGES);
    found   = 1'b0;
    case (r.req_type)
      REQ_ALLOC: begin
        // first fit from the lowest page
        for (int i = 0; i < NUM_PAGES; i++) begin
          if (!found && !page_taken[i]) begin
            found            = 1'b1;
            page_taken[i]    = 1'b1;
            free_left        = free_left - 1'b1;
            res.granted_page = PAGE_W'(i + 1);
          end
        end
        res.alloc_failed = !found;
      end
      REQ_RELEASE: begin
        if (page_ok && page_taken[page-1]) begin
          page_taken[page-1] = 1'b0;
          free_left          = free_left + 1'b1;
        end
      end
      REQ_MARK: begin
        if (page_ok && !page_taken[page-1]) begin
          page_taken[page-1] = 1'b1;
          free_left          = free_left - 1'b1;
        end
      end
      default: begin
        page_taken = '0;
        free_left  = CNT_W'(NUM_PAGES);
      end
    endcase
    res.free_pages = free_left;
    return res;
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      page_taken = '0;
      free_left  = CNT_W'(NUM_PAGES);
      grant_q.delete();
    end else begin
      // compare before predicting: a request never completes in the cycle it is taken
      if (out_pop && !out_empty) begin
        results_seen++;
        if (grant_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d arrived with nothing outstanding: granted %0d failed %0b free %0d",
                     results_seen, out_res.granted_page, out_res.alloc_failed,
                     out_res.free_pages);
        end else begin
          want = grant_q.pop_front();
          if (out_res.granted_page !== want.granted_page ||
              out_res.alloc_failed !== want.alloc_failed ||
              out_res.free_pages   !== want.free_pages) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result %0d mismatch: granted exp %0d got %0d, failed exp %0b got %0b, free exp %0d got %0d",
                       results_seen, want.granted_page, out_res.granted_page,
                       want.alloc_failed, out_res.alloc_failed,
                       want.free_pages, out_res.free_pages);
          end
        end
      end
      if (in_push && !in_full)
        grant_q.push_back(apply_request(in_req));
    end
    fail_count      <= mismatches;
    pending_results <= grant_q.size();
  end

endmodule

// ===== tb/sv/flash_page_bitmap_allocator_tb.sv =====
// top of the flash page bitmap allocator testbench: clock, reset, request stimulus,
// result pop pacing, watchdog and verdict
// depends on fpba_pkg, flash_page_bitmap_allocator and flash_page_bitmap_allocator_checker
`timescale 1ns / 100ps
module flash_page_bitmap_allocator_tb;
  import fpba_pkg::*;

  localparam int IDLE_LIMIT    = 5000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 60;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     in_push = 1'b0;
  logic     in_full;
  in_req_t  in_req  = '0;
  logic     out_empty;
  logic     out_pop = 1'b0;
  out_res_t out_res;

  int fail_count;
  int pending_results;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request  = 1'b0;
  int quiet_cycles  = 0;

  always #5 clk = ~clk;

  flash_page_bitmap_allocator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_req    (in_req),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_res   (out_res)
  );

  flash_page_bitmap_allocator_checker result_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req          (in_req),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_res         (out_res),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[flash_page_bitmap_allocator] ERROR");
      $finish;
    end
  end

  // result side pacing, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic in_req_t make_req(logic [1:0] kind, int unsigned page);
    in_req_t r;
    r.req_type    = kind;
    r.page_number = PAGE_W'(page);
    return r;
  endfunction

  // mostly real pages, some page zero and some beyond the store
  function automatic int unsigned rand_page();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6)
      return 0;
    if (pick < 13)
      return $urandom_range(511, NUM_PAGES + 1);
    return $urandom_range(NUM_PAGES, 1);
  endfunction

  function automatic in_req_t rand_req();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)
      return make_req(REQ_ALLOC, $urandom_range(511));
    if (pick < 70)
      return make_req(REQ_RELEASE, rand_page());
    if (pick < 97)
      return make_req(REQ_MARK, rand_page());
    return make_req(REQ_CLEAR, $urandom_range(511));
  endfunction

  // returns in the step of the accepting edge with in_push still high
  task automatic send_req(input in_req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct)
      gap++;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_req  <= r;
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic random_traffic(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 25) begin
        // allocate bursts push the map toward full
        burst = $urandom_range(12, 2);
        repeat (burst) send_req(make_req(REQ_ALLOC, $urandom_range(511)));
        sent += burst;
      end else begin
        send_req(rand_req());
        sent++;
      end
    end
  endtask

  initial begin
    int keep_pct;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 10;
    recv_idle_pct = 48;

    // directed: holes, ignored pages, no-op release and mark, last page, clear-all
    send_req(make_req(REQ_ALLOC, 0));
    send_req(make_req(REQ_ALLOC, 511));
    send_req(make_req(REQ_MARK, 3));
    send_req(make_req(REQ_ALLOC, 0));
    send_req(make_req(REQ_RELEASE, 2));
    send_req(make_req(REQ_ALLOC, 0));
    send_req(make_req(REQ_RELEASE, 0));
    send_req(make_req(REQ_MARK, 0));
    send_req(make_req(REQ_RELEASE, 257));
    send_req(make_req(REQ_MARK, 511));
    send_req(make_req(REQ_RELEASE, 300));
    send_req(make_req(REQ_RELEASE, 10));
    send_req(make_req(REQ_MARK, 1));
    send_req(make_req(REQ_MARK, 256));
    send_req(make_req(REQ_RELEASE, 256));
    send_req(make_req(REQ_RELEASE, 128));
    send_req(make_req(REQ_MARK, 255));
    send_req(make_req(REQ_CLEAR, 511));
    send_req(make_req(REQ_CLEAR, 0));
    send_req(make_req(REQ_ALLOC, 0));
    send_req(make_req(REQ_RELEASE, 1));

    // back-pressure: results held off while requests keep coming
    keep_pct      = send_idle_pct;
    send_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (12) send_req(rand_req());
    send_idle_pct = keep_pct;

    random_traffic(180);
    drain_results();

    send_idle_pct = 48;
    recv_idle_pct = 10;
    random_traffic(190);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // fill the whole map, then allocate past full
    send_req(make_req(REQ_CLEAR, $urandom_range(511)));
    repeat (NUM_PAGES + 2) send_req(make_req(REQ_ALLOC, $urandom_range(511)));
    repeat (8) send_req(make_req(REQ_RELEASE, $urandom_range(NUM_PAGES, 1)));
    repeat (10) send_req(make_req(REQ_ALLOC, $urandom_range(511)));
    random_traffic(10);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("[flash_page_bitmap_allocator] OK");
    else
      $display("[flash_page_bitmap_allocator] ERROR");
    $finish;
  end

endmodule
